@@ src/owb_pkg.sv @@
// Shared types, register indexes and constants of the 1-Wire bus master.
`default_nettype none

package owb_pkg;

    localparam int CFG_W            = 16;
    localparam int CFG_IDX_W        = 3;
    localparam int TIMER_BITS_DEF   = 16;
    localparam int S_TDATA_W        = 32;
    localparam int M_TDATA_W        = 16;

    localparam logic [7:0] SKIP_ROM = 8'hCC;

    // request commands
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;
    localparam logic [1:0] CMD_ONLY  = 2'd3;

    // byte sequence position
    localparam logic [1:0] STEP_SKIP = 2'd0;
    localparam logic [1:0] STEP_FUNC = 2'd1;
    localparam logic [1:0] STEP_ADDR = 2'd2;
    localparam logic [1:0] STEP_DATA = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_TAIL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT          = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_ONE_LOW = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_ZERO_LOW= 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLE   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RETRY_WAIT    = 3'd7;

    // register reset values
    localparam logic [CFG_W-1:0] DEF_RESET_LOW      = 16'd480;
    localparam logic [CFG_W-1:0] DEF_PRESENCE_WAIT  = 16'd70;
    localparam logic [CFG_W-1:0] DEF_RESET_TAIL     = 16'd410;
    localparam logic [CFG_W-1:0] DEF_SLOT           = 16'd65;
    localparam logic [CFG_W-1:0] DEF_WRITE_ONE_LOW  = 16'd6;
    localparam logic [CFG_W-1:0] DEF_WRITE_ZERO_LOW = 16'd60;
    localparam logic [CFG_W-1:0] DEF_READ_SAMPLE    = 16'd9;
    localparam logic [CFG_W-1:0] DEF_RETRY_WAIT     = 16'd100;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_RST_LOW  = 4'd1,
        PH_RST_WAIT = 4'd2,
        PH_RST_TAIL = 4'd3,
        PH_RETRY    = 4'd4,
        PH_WRITE    = 4'd5,
        PH_READ     = 4'd6
    } phase_t;

    typedef struct packed {
        logic [CFG_W-1:0] reset_low_ticks;
        logic [CFG_W-1:0] presence_wait_ticks;
        logic [CFG_W-1:0] reset_tail_ticks;
        logic [CFG_W-1:0] slot_ticks;
        logic [CFG_W-1:0] write_one_low_ticks;
        logic [CFG_W-1:0] write_zero_low_ticks;
        logic [CFG_W-1:0] read_sample_ticks;
        logic [CFG_W-1:0] retry_wait_ticks;
    } cfg_t;

    typedef struct packed {
        phase_t     phase;
        logic [2:0] bit_index;
        logic [1:0] byte_step;
        logic [7:0] shift_byte;
        logic [7:0] held_function;
        logic [7:0] held_address;
        logic [7:0] held_data;
        logic [1:0] transaction_kind;
        logic [7:0] read_hold;
    } ctl_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] function_code;
        logic [7:0] reg_address;
        logic [7:0] write_value;
        logic       line_sample;
    } req_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_value;
        logic       no_device;
    } res_t;

endpackage

`default_nettype wire

@@ src/owb_step.sv @@
// Next-state and result logic for one bus tick of the 1-Wire master.
`default_nettype none

module owb_step
    import owb_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  var cfg_t                  cfg,
    input  var ctl_t                  ctl_in,
    input  wire logic [TIMER_BITS-1:0] tick_in,
    input  var req_t                  req,
    output var ctl_t                  ctl_out,
    output logic      [TIMER_BITS-1:0] tick_out,
    output var res_t                  res
);

    // compare width: holds any register value plus one and the timer maximum
    localparam int CW = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
    localparam int W  = CW + 1;
    localparam logic [W-1:0] TMAX = W'((64'd1 << TIMER_BITS) - 64'd1);
    localparam logic [TIMER_BITS-1:0] TICK_SAT = {TIMER_BITS{1'b1}};

    function automatic logic [W-1:0] tgt(input logic [CFG_W-1:0] r);
        logic [W-1:0] e;
        e = W'(r);
        return (e > TMAX) ? TMAX : e;
    endfunction

    ctl_t                  c;
    logic [TIMER_BITS-1:0] t;
    logic [CFG_W-1:0]      low_sel;
    logic [W-1:0]          slot_t;
    logic [W-1:0]          last_t;
    logic [W-1:0]          samp_t;
    logic                  drive;
    logic                  busy;
    logic                  done;
    logic                  nodev;

    always_comb begin
        c       = ctl_in;
        t       = tick_in;
        drive   = 1'b0;
        busy    = 1'b0;
        done    = 1'b0;
        nodev   = 1'b0;
        low_sel = c.shift_byte[0] ? cfg.write_one_low_ticks : cfg.write_zero_low_ticks;
        slot_t  = tgt(cfg.slot_ticks);
        last_t  = (slot_t >= W'(1)) ? slot_t - W'(1) : '0;
        samp_t  = W'(cfg.read_sample_ticks) + W'(1);
        if (samp_t > last_t) begin
            samp_t = last_t;
        end

        // start request taken only while idle
        if (c.phase == PH_IDLE && req.cmd != CMD_TICK) begin
            c.held_function    = req.function_code;
            c.held_address     = req.reg_address;
            c.held_data        = req.write_value;
            c.transaction_kind = req.cmd;
            c.phase            = PH_RST_LOW;
            t                  = '0;
        end
        busy = (c.phase != PH_IDLE);
        low_sel = c.shift_byte[0] ? cfg.write_one_low_ticks : cfg.write_zero_low_ticks;

        case (c.phase)
            PH_RST_LOW: begin
                drive = 1'b1;
                t = (t == TICK_SAT) ? t : t + 1'b1;
                if (W'(t) >= tgt(cfg.reset_low_ticks)) begin
                    c.phase = PH_RST_WAIT;
                    t = '0;
                end
            end
            PH_RST_WAIT: begin
                t = (t == TICK_SAT) ? t : t + 1'b1;
                if (W'(t) >= tgt(cfg.presence_wait_ticks)) begin
                    t = '0;
                    if (req.line_sample) begin
                        nodev = 1'b1;
                        c.phase = (tgt(cfg.retry_wait_ticks) == '0) ? PH_RST_LOW : PH_RETRY;
                    end else if (tgt(cfg.reset_tail_ticks) == '0) begin
                        c.phase      = PH_WRITE;
                        c.bit_index  = '0;
                        c.byte_step  = STEP_SKIP;
                        c.shift_byte = SKIP_ROM;
                    end else begin
                        c.phase = PH_RST_TAIL;
                    end
                end
            end
            PH_RST_TAIL: begin
                t = (t == TICK_SAT) ? t : t + 1'b1;
                if (W'(t) >= tgt(cfg.reset_tail_ticks)) begin
                    c.phase      = PH_WRITE;
                    t            = '0;
                    c.bit_index  = '0;
                    c.byte_step  = STEP_SKIP;
                    c.shift_byte = SKIP_ROM;
                end
            end
            PH_RETRY: begin
                t = (t == TICK_SAT) ? t : t + 1'b1;
                if (W'(t) >= tgt(cfg.retry_wait_ticks)) begin
                    c.phase = PH_RST_LOW;
                    t = '0;
                end
            end
            PH_WRITE: begin
                drive = (W'(t) < tgt(low_sel));
                t = (t == TICK_SAT) ? t : t + 1'b1;
                if (W'(t) >= slot_t) begin
                    c.shift_byte = c.shift_byte >> 1;
                    c.bit_index  = c.bit_index + 3'd1;
                    t            = '0;
                    if (c.bit_index == '0) begin
                        done = 1'b1;
                        case (c.byte_step)
                            STEP_SKIP: begin
                                done         = 1'b0;
                                c.byte_step  = STEP_FUNC;
                                c.shift_byte = c.held_function;
                            end
                            STEP_FUNC: begin
                                done         = 1'b0;
                                c.byte_step  = STEP_ADDR;
                                c.shift_byte = c.held_address;
                            end
                            STEP_ADDR: begin
                                if (c.transaction_kind == CMD_READ) begin
                                    done         = 1'b0;
                                    c.phase      = PH_READ;
                                    c.shift_byte = '0;
                                end else if (c.transaction_kind == CMD_WRITE) begin
                                    done         = 1'b0;
                                    c.byte_step  = STEP_DATA;
                                    c.shift_byte = c.held_data;
                                end
                            end
                            default: ;
                        endcase
                        if (done) begin
                            c.phase = PH_IDLE;
                        end
                    end
                end
            end
            PH_READ: begin
                drive = (t == '0);
                if (W'(t) == samp_t) begin
                    c.shift_byte = {req.line_sample, c.shift_byte[7:1]};
                end
                t = (t == TICK_SAT) ? t : t + 1'b1;
                if (W'(t) >= slot_t) begin
                    t = '0;
                    c.bit_index = c.bit_index + 3'd1;
                    if (c.bit_index == '0) begin
                        c.read_hold = c.shift_byte;
                        c.phase     = PH_IDLE;
                        done        = 1'b1;
                    end
                end
            end
            default: begin
                c.phase = PH_IDLE;
            end
        endcase

        ctl_out        = c;
        tick_out       = t;
        res.drive_low  = drive;
        res.busy_res   = busy;
        res.done_res   = done;
        res.read_value = c.read_hold;
        res.no_device  = nodev;
    end

endmodule

`default_nettype wire

@@ src/one_wire_bus_master.sv @@
// Top level of the 1-Wire bus master: stream ports, timing registers, state registers.
`default_nettype none

// Each input request is a bus tick (nominally a microsecond). A request with
// cmd 1 (read), 2 (write) or 3 (command only) starts a transaction when the master
// is idle: reset pulse, presence sample (retrying after retry_wait_ticks when no
// device answers), skip-ROM 0xCC, function code, address, then for read or write
// one data byte, all LSB first. Start requests while busy are ignored. Each
// accepted request yields exactly one result; drive_low must be applied to the line
// for that tick. Throughput is one request per clock unless the slave side stalls;
// the result of a request is presented in the cycle after it is accepted, from the
// output register; the slave side stalls only while m_tready has not taken it.

module one_wire_bus_master
    import owb_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // input: [1:0] cmd, [9:2] function_code, [17:10] reg_address,
    //        [25:18] write_value, [26] line_sample, [31:27] zero
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // result: [0] drive_low, [1] busy_res, [2] done_res, [10:3] read_value,
    //         [11] no_device, [15:12] zero
    output logic      [M_TDATA_W-1:0]  m_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data
);

    cfg_t                  cfg_reg;
    ctl_t                  ctl_reg;
    ctl_t                  ctl_next;
    logic [TIMER_BITS-1:0] tick_reg;
    logic [TIMER_BITS-1:0] tick_next;
    res_t                  res_next;
    res_t                  res_reg;
    logic                  m_tvalid_reg;
    req_t                  req;
    logic                  s_take;

    assign req.cmd           = s_tdata[1:0];
    assign req.function_code = s_tdata[9:2];
    assign req.reg_address   = s_tdata[17:10];
    assign req.write_value   = s_tdata[25:18];
    assign req.line_sample   = s_tdata[26];

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign s_take    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    owb_step #(
        .TIMER_BITS (TIMER_BITS)
    ) u_step (
        .cfg      (cfg_reg),
        .ctl_in   (ctl_reg),
        .tick_in  (tick_reg),
        .req      (req),
        .ctl_out  (ctl_next),
        .tick_out (tick_next),
        .res      (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.reset_low_ticks      <= DEF_RESET_LOW;
            cfg_reg.presence_wait_ticks  <= DEF_PRESENCE_WAIT;
            cfg_reg.reset_tail_ticks     <= DEF_RESET_TAIL;
            cfg_reg.slot_ticks           <= DEF_SLOT;
            cfg_reg.write_one_low_ticks  <= DEF_WRITE_ONE_LOW;
            cfg_reg.write_zero_low_ticks <= DEF_WRITE_ZERO_LOW;
            cfg_reg.read_sample_ticks    <= DEF_READ_SAMPLE;
            cfg_reg.retry_wait_ticks     <= DEF_RETRY_WAIT;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_RESET_LOW:      cfg_reg.reset_low_ticks      <= cfg_data;
                REG_PRESENCE_WAIT:  cfg_reg.presence_wait_ticks  <= cfg_data;
                REG_RESET_TAIL:     cfg_reg.reset_tail_ticks     <= cfg_data;
                REG_SLOT:           cfg_reg.slot_ticks           <= cfg_data;
                REG_WRITE_ONE_LOW:  cfg_reg.write_one_low_ticks  <= cfg_data;
                REG_WRITE_ZERO_LOW: cfg_reg.write_zero_low_ticks <= cfg_data;
                REG_READ_SAMPLE:    cfg_reg.read_sample_ticks    <= cfg_data;
                REG_RETRY_WAIT:     cfg_reg.retry_wait_ticks     <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg      <= '0;
            tick_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (s_take) begin
                ctl_reg      <= ctl_next;
                tick_reg     <= tick_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_take) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, res_reg.no_device, res_reg.read_value,
                       res_reg.done_res, res_reg.busy_res, res_reg.drive_low};

endmodule

`default_nettype wire

@@ sim/one_wire_bus_master_test.sv @@
// Testbench for one_wire_bus_master: tick-by-tick predicted outputs checked over timing sweeps.
`timescale 1ns / 100ps

module one_wire_bus_master_test;
    import owb_pkg::*;

    localparam int unsigned TICK_MAX    = (1 << TIMER_BITS_DEF) - 1;
    localparam int unsigned HOLD_CYCLES = 240;
    localparam int unsigned LINE_LOW    = 0;
    localparam int unsigned LINE_HIGH   = 1;
    localparam int unsigned LINE_RANDOM = 2;

    class bus_scoreboard;
        cfg_t        timing;
        phase_t      phase;
        int unsigned tick_count;
        logic [2:0]  bit_index;
        logic [1:0]  byte_step;
        logic [7:0]  shift_byte;
        logic [7:0]  held_function;
        logic [7:0]  held_address;
        logic [7:0]  held_data;
        logic [7:0]  read_hold;
        logic [1:0]  kind;
        res_t        line_results_due[$];
        int unsigned errors, ticks, reads, writes, cmd_only, misses;

        function new();
            timing = '{reset_low_ticks: DEF_RESET_LOW, presence_wait_ticks: DEF_PRESENCE_WAIT,
                       reset_tail_ticks: DEF_RESET_TAIL, slot_ticks: DEF_SLOT,
                       write_one_low_ticks: DEF_WRITE_ONE_LOW,
                       write_zero_low_ticks: DEF_WRITE_ZERO_LOW,
                       read_sample_ticks: DEF_READ_SAMPLE, retry_wait_ticks: DEF_RETRY_WAIT};
            phase = PH_IDLE;
            tick_count = 0;
            bit_index = '0;
            byte_step = STEP_SKIP;
            shift_byte = '0;
            held_function = '0;
            held_address = '0;
            held_data = '0;
            read_hold = '0;
            kind = CMD_TICK;
            errors = 0; ticks = 0; reads = 0; writes = 0; cmd_only = 0; misses = 0;
        endfunction

        function void set_timing(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_RESET_LOW:      timing.reset_low_ticks = val;
                REG_PRESENCE_WAIT:  timing.presence_wait_ticks = val;
                REG_RESET_TAIL:     timing.reset_tail_ticks = val;
                REG_SLOT:           timing.slot_ticks = val;
                REG_WRITE_ONE_LOW:  timing.write_one_low_ticks = val;
                REG_WRITE_ZERO_LOW: timing.write_zero_low_ticks = val;
                REG_READ_SAMPLE:    timing.read_sample_ticks = val;
                REG_RETRY_WAIT:     timing.retry_wait_ticks = val;
                default: ;
            endcase
        endfunction

        function bit presence_sample_due();
            return phase == PH_RST_WAIT && tick_count + 1 >= timing.presence_wait_ticks;
        endfunction

        function void bump_tick();
            if (tick_count < TICK_MAX) tick_count++;
        endfunction

        function void start_bytes();
            phase = PH_WRITE;
            tick_count = 0;
            bit_index = '0;
            byte_step = STEP_SKIP;
            shift_byte = SKIP_ROM;
        endfunction

        // returns 1 when the last slot of the transaction ends
        function bit end_write_slot();
            shift_byte = shift_byte >> 1;
            bit_index = bit_index + 3'd1;
            tick_count = 0;
            if (bit_index != 0) return 1'b0;
            case (byte_step)
                STEP_SKIP: begin
                    byte_step = STEP_FUNC;
                    shift_byte = held_function;
                    return 1'b0;
                end
                STEP_FUNC: begin
                    byte_step = STEP_ADDR;
                    shift_byte = held_address;
                    return 1'b0;
                end
                STEP_ADDR: begin
                    if (kind == CMD_READ) begin
                        phase = PH_READ;
                        shift_byte = '0;
                        return 1'b0;
                    end
                    if (kind == CMD_WRITE) begin
                        byte_step = STEP_DATA;
                        shift_byte = held_data;
                        return 1'b0;
                    end
                end
                default: ;
            endcase
            phase = PH_IDLE;
            if (kind == CMD_WRITE) writes++;
            else cmd_only++;
            return 1'b1;
        endfunction

        function res_t advance_bus(req_t r);
            res_t        e;
            int unsigned low, slot, last_tick, sample_at;
            e = '0;
            if (phase == PH_IDLE && r.cmd != CMD_TICK) begin
                held_function = r.function_code;
                held_address = r.reg_address;
                held_data = r.write_value;
                kind = r.cmd;
                phase = PH_RST_LOW;
                tick_count = 0;
            end
            e.busy_res = (phase != PH_IDLE);
            case (phase)
                PH_RST_LOW: begin
                    e.drive_low = 1'b1;
                    bump_tick();
                    if (tick_count >= timing.reset_low_ticks) begin
                        phase = PH_RST_WAIT;
                        tick_count = 0;
                    end
                end
                PH_RST_WAIT: begin
                    bump_tick();
                    if (tick_count >= timing.presence_wait_ticks) begin
                        tick_count = 0;
                        if (r.line_sample) begin
                            e.no_device = 1'b1;
                            misses++;
                            if (timing.retry_wait_ticks == 0) phase = PH_RST_LOW;
                            else phase = PH_RETRY;
                        end else if (timing.reset_tail_ticks == 0) begin
                            start_bytes();
                        end else begin
                            phase = PH_RST_TAIL;
                        end
                    end
                end
                PH_RST_TAIL: begin
                    bump_tick();
                    if (tick_count >= timing.reset_tail_ticks) start_bytes();
                end
                PH_RETRY: begin
                    bump_tick();
                    if (tick_count >= timing.retry_wait_ticks) begin
                        phase = PH_RST_LOW;
                        tick_count = 0;
                    end
                end
                PH_WRITE: begin
                    low = shift_byte[0] ? timing.write_one_low_ticks : timing.write_zero_low_ticks;
                    e.drive_low = (tick_count < low);
                    bump_tick();
                    if (tick_count >= timing.slot_ticks) e.done_res = end_write_slot();
                end
                PH_READ: begin
                    slot = timing.slot_ticks;
                    last_tick = (slot >= 1) ? slot - 1 : 0;
                    sample_at = timing.read_sample_ticks + 1;
                    // a sample point past the slot falls on its last tick
                    if (sample_at > last_tick) sample_at = last_tick;
                    e.drive_low = (tick_count == 0);
                    if (tick_count == sample_at) shift_byte = {r.line_sample, shift_byte[7:1]};
                    bump_tick();
                    if (tick_count >= slot) begin
                        tick_count = 0;
                        bit_index = bit_index + 3'd1;
                        if (bit_index == 0) begin
                            read_hold = shift_byte;
                            phase = PH_IDLE;
                            e.done_res = 1'b1;
                            reads++;
                        end
                    end
                end
                default: phase = PH_IDLE;
            endcase
            e.read_value = read_hold;
            return e;
        endfunction

        function void note_request(req_t r);
            ticks++;
            line_results_due.push_back(advance_bus(r));
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] d);
            res_t e;
            if (line_results_due.size() == 0) begin
                $error("result %h with no request outstanding", d);
                errors++;
                return;
            end
            e = line_results_due.pop_front();
            if (d[0] !== e.drive_low) begin
                $error("drive_low: expected %0d, got %0d", e.drive_low, d[0]);
                errors++;
            end
            if (d[1] !== e.busy_res) begin
                $error("busy_res: expected %0d, got %0d", e.busy_res, d[1]);
                errors++;
            end
            if (d[2] !== e.done_res) begin
                $error("done_res: expected %0d, got %0d", e.done_res, d[2]);
                errors++;
            end
            if (d[10:3] !== e.read_value) begin
                $error("read_value: expected %h, got %h", e.read_value, d[10:3]);
                errors++;
            end
            if (d[11] !== e.no_device) begin
                $error("no_device: expected %0d, got %0d", e.no_device, d[11]);
                errors++;
            end
        endfunction

        function void check_drained();
            if (line_results_due.size() != 0) begin
                $error("%0d results never arrived", line_results_due.size());
                errors++;
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data = '0;

    logic                  rx_hold = 1'b0;
    bit                    hold_start = 1'b0;
    int unsigned           src_idle_pct = 0;
    int unsigned           sink_stall_pct = 0;

    bus_scoreboard board = new();

    one_wire_bus_master uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_result(m_tdata);
        if (rx_hold) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // long receiver hold-off so the output register fills and s_tready drops
    initial begin
        wait (hold_start);
        @(posedge aclk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    initial begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

    task automatic send_tick(req_t r);
        int unsigned gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < src_idle_pct) gap++;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata <= {5'b0, r.line_sample, r.write_value, r.reg_address, r.function_code, r.cmd};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        board.note_request(r);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        board.set_timing(idx, val);
    endtask

    task automatic load_timings(cfg_t c);
        write_reg(REG_RESET_LOW, c.reset_low_ticks);
        write_reg(REG_PRESENCE_WAIT, c.presence_wait_ticks);
        write_reg(REG_RESET_TAIL, c.reset_tail_ticks);
        write_reg(REG_SLOT, c.slot_ticks);
        write_reg(REG_WRITE_ONE_LOW, c.write_one_low_ticks);
        write_reg(REG_WRITE_ZERO_LOW, c.write_zero_low_ticks);
        write_reg(REG_READ_SAMPLE, c.read_sample_ticks);
        write_reg(REG_RETRY_WAIT, c.retry_wait_ticks);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic idle_ticks(int unsigned n);
        req_t r;
        repeat (n) begin
            r.cmd = CMD_TICK;
            r.function_code = 8'($urandom);
            r.reg_address = 8'($urandom);
            r.write_value = 8'($urandom);
            r.line_sample = 1'($urandom_range(1));
            send_tick(r);
        end
    endtask

    task automatic run_transaction(logic [1:0] cmd, logic [7:0] fn, logic [7:0] addr,
                                   logic [7:0] data, int unsigned line_mode,
                                   int unsigned forced_misses, int unsigned miss_pct,
                                   int unsigned restart_pct);
        req_t        r;
        int unsigned forced;
        forced = forced_misses;
        r.cmd = cmd;
        r.function_code = fn;
        r.reg_address = addr;
        r.write_value = data;
        r.line_sample = 1'($urandom_range(1));
        send_tick(r);
        while (board.phase != PH_IDLE) begin
            r.cmd = CMD_TICK;
            // starts while busy must be ignored
            if ($urandom_range(99) < restart_pct) begin
                r.cmd = 2'($urandom_range(CMD_READ, CMD_ONLY));
                r.function_code = 8'($urandom);
                r.reg_address = 8'($urandom);
                r.write_value = 8'($urandom);
            end
            if (board.presence_sample_due()) begin
                if (forced != 0) begin
                    r.line_sample = 1'b1;
                    forced--;
                end else begin
                    r.line_sample = ($urandom_range(99) < miss_pct);
                end
            end else if (line_mode == LINE_RANDOM) begin
                r.line_sample = 1'($urandom_range(1));
            end else begin
                r.line_sample = (line_mode == LINE_HIGH);
            end
            send_tick(r);
        end
    endtask

    task automatic finish_phase();
        int unsigned n;
        n = 0;
        s_tvalid <= 1'b0;
        while (board.line_results_due.size() != 0 && n < 5000) begin
            @(posedge aclk);
            n++;
        end
        repeat (4) @(posedge aclk);
    endtask

    function automatic cfg_t tiny_timings();
        cfg_t c;
        c.reset_low_ticks = CFG_W'($urandom_range(0, 4));
        c.presence_wait_ticks = CFG_W'($urandom_range(0, 4));
        c.reset_tail_ticks = CFG_W'($urandom_range(0, 3));
        c.slot_ticks = CFG_W'($urandom_range(0, 3));
        c.write_one_low_ticks = CFG_W'($urandom_range(0, 6));
        c.write_zero_low_ticks = CFG_W'($urandom_range(0, 7));
        c.read_sample_ticks = CFG_W'($urandom_range(0, 7));
        c.retry_wait_ticks = CFG_W'($urandom_range(0, 3));
        return c;
    endfunction

    task automatic random_phase(int unsigned src_pct, int unsigned sink_pct,
                                int unsigned min_ticks, bit with_hold);
        int unsigned first_tick;
        src_idle_pct = src_pct;
        sink_stall_pct = sink_pct;
        load_timings(tiny_timings());
        if (with_hold) hold_start = 1'b1;
        first_tick = board.ticks;
        while (board.ticks - first_tick < min_ticks) begin
            idle_ticks($urandom_range(0, 3));
            run_transaction(2'($urandom_range(CMD_READ, CMD_ONLY)), 8'($urandom),
                            8'($urandom), 8'($urandom), LINE_RANDOM, 0, 15, 8);
        end
        finish_phase();
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset timings, idle, read value still zero
        idle_ticks(3);
        finish_phase();

        // all timings zero: reset low, presence wait and each bit slot take one tick; tail and retry are skipped
        load_timings('{reset_low_ticks: 16'd0, presence_wait_ticks: 16'd0,
                       reset_tail_ticks: 16'd0, slot_ticks: 16'd0,
                       write_one_low_ticks: 16'd0, write_zero_low_ticks: 16'd0,
                       read_sample_ticks: 16'd0, retry_wait_ticks: 16'd0});
        run_transaction(CMD_READ, 8'hFF, 8'h00, 8'h00, LINE_HIGH, 0, 0, 0);
        run_transaction(CMD_WRITE, 8'h00, 8'hFF, 8'hA5, LINE_RANDOM, 0, 0, 0);
        run_transaction(CMD_ONLY, 8'h81, 8'h7E, 8'hFF, LINE_RANDOM, 2, 0, 0);
        finish_phase();

        // zero low time at the slot, one low time below it, read sample past the slot end
        load_timings('{reset_low_ticks: 16'd2, presence_wait_ticks: 16'd3,
                       reset_tail_ticks: 16'd1, slot_ticks: 16'd2,
                       write_one_low_ticks: 16'd1, write_zero_low_ticks: 16'd2,
                       read_sample_ticks: 16'd7, retry_wait_ticks: 16'd2});
        idle_ticks(2);
        run_transaction(CMD_READ, 8'h00, 8'hFF, 8'h00, LINE_LOW, 0, 0, 0);
        run_transaction(CMD_WRITE, 8'hFF, 8'h00, 8'h5A, LINE_RANDOM, 0, 0, 0);
        run_transaction(CMD_READ, 8'h96, 8'h69, 8'h0F, LINE_RANDOM, 1, 0, 30);
        finish_phase();

        random_phase(0, 0, 40, 1'b1);
        random_phase(76, 0, 40, 1'b0);
        random_phase(0, 76, 40, 1'b0);
        random_phase(34, 34, 40, 1'b0);

        // full-scale low and sample times, one missed presence before the retry
        src_idle_pct = 0;
        sink_stall_pct = 0;
        load_timings('{reset_low_ticks: 16'd3, presence_wait_ticks: 16'd2,
                       reset_tail_ticks: 16'd0, slot_ticks: 16'd2,
                       write_one_low_ticks: 16'hFFFF, write_zero_low_ticks: 16'hFFFF,
                       read_sample_ticks: 16'hFFFF, retry_wait_ticks: 16'd1});
        run_transaction(CMD_READ, 8'hA5, 8'h5A, 8'h00, LINE_RANDOM, 1, 0, 2);
        finish_phase();

        board.check_drained();
        $display("%0d ticks checked: %0d reads, %0d writes, %0d command-only transactions",
                 board.ticks, board.reads, board.writes, board.cmd_only);
        $display("%0d presence samples found no device; timings from all-zero to full-scale",
                 board.misses);
        if (board.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
